@@ hdl/lfr_pkg.sv @@
package lfr_pkg;

   localparam int CMD_W          = 2;
   localparam int FRAME_W        = 6;
   localparam int COUNT_W        = 7;
   localparam int NUM_FRAMES_DEF = 64;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_VICTIM = 2'd0,
      CMD_PIN    = 2'd1,
      CMD_UNPIN  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_APPEND,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;
      logic capture;
      logic exec_en;
      logic append_en;
      logic load_out;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic need_append;
      logic out_free;
   } dp_status_type;

endpackage

@@ hdl/lfr_req_if.sv @@
interface lfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [lfr_pkg::CMD_W-1:0]    cmd;
   logic [lfr_pkg::FRAME_W-1:0]  frame;

   modport source (output valid, cmd, frame, input ready);
   modport sink   (input valid, cmd, frame, output ready);
endinterface

@@ hdl/lfr_rsp_if.sv @@
interface lfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [lfr_pkg::FRAME_W-1:0]  victim_frame;
   logic                         dropped;
   logic [lfr_pkg::COUNT_W-1:0]  count;

   modport source (output valid, ok, victim_frame, dropped, count, input ready);
   modport sink   (input valid, ok, victim_frame, dropped, count, output ready);
endinterface

@@ hdl/lfr_csr_if.sv @@
interface lfr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lfr_pkg::COUNT_W-1:0]  list_limit;

   modport source (output valid, list_limit, input ready);
   modport sink   (input valid, list_limit, output ready);
endinterface

@@ hdl/lfr_ram.sv @@
module lfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/lfr_ctrl.sv @@
module lfr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lfr_pkg::dp_status_type status,
   output lfr_pkg::ctrl_cmd_type  ctrl
);

   lfr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfr_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfr_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = lfr_pkg::ST_IDLE;
         end
         lfr_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfr_pkg::ST_EXEC;
         end
         lfr_pkg::ST_EXEC: begin
            state_in = status.need_append ? lfr_pkg::ST_APPEND : lfr_pkg::ST_DONE;
         end
         lfr_pkg::ST_APPEND: begin
            state_in = lfr_pkg::ST_DONE;
         end
         lfr_pkg::ST_DONE: begin
            if (status.out_free) state_in = lfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lfr_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         lfr_pkg::ST_CLEAR: begin
            ctrl.clear_en = 1'b1;
         end
         lfr_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         lfr_pkg::ST_EXEC: begin
            ctrl.exec_en = 1'b1;
         end
         lfr_pkg::ST_APPEND: begin
            ctrl.append_en = 1'b1;
         end
         lfr_pkg::ST_DONE: begin
            ctrl.load_out = status.out_free;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

@@ hdl/lfr_dp.sv @@
module lfr_dp #(
   parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfr_pkg::ctrl_cmd_type         ctrl,
   output lfr_pkg::dp_status_type        status,
   input  logic [lfr_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lfr_pkg::FRAME_W-1:0]   req_frame,
   input  logic                          csr_valid,
   input  logic [lfr_pkg::COUNT_W-1:0]   csr_list_limit,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [lfr_pkg::FRAME_W-1:0]   rsp_victim_frame,
   output logic                          rsp_dropped,
   output logic [lfr_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = lfr_pkg::COUNT_W;

   lfr_pkg::cmd_type            cmd_ff, cmd_in;
   logic [lfr_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [FW-1:0]               head_ff, head_in;
   logic [FW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               limit_ff, limit_in;
   logic [FW-1:0]               clr_ff, clr_in;
   logic                        res_ok_ff, res_ok_in;
   logic [lfr_pkg::FRAME_W-1:0] res_vf_ff, res_vf_in;
   logic                        res_drop_ff, res_drop_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_ok_ff, out_ok_in;
   logic [lfr_pkg::FRAME_W-1:0] out_vf_ff, out_vf_in;
   logic                        out_drop_ff, out_drop_in;
   logic [CW-1:0]               out_count_ff, out_count_in;

   logic                        mark_we, mark_wd, mark_rd;
   logic [FW-1:0]               mark_addr;
   logic                        prev_we, next_we;
   logic [FW-1:0]               prev_addr, prev_wd, prev_rd;
   logic [FW-1:0]               next_addr, next_wd, next_rd;

   logic [FW-1:0]               x_idx;
   logic                        frame_ok, at_cap, drop_need;

   assign x_idx     = FW'(frame_ff);
   assign frame_ok  = 32'(frame_ff) < 32'(NUM_FRAMES);
   assign at_cap    = (count_ff >= limit_ff) || (32'(count_ff) >= 32'(NUM_FRAMES));
   assign drop_need = (count_ff != '0) && at_cap;

   assign status.clear_last  = clr_ff == FW'(NUM_FRAMES - 1);
   assign status.need_append = (cmd_ff == lfr_pkg::CMD_UNPIN) && frame_ok && !mark_rd;
   assign status.out_free    = !out_valid_ff || rsp_ready;

   lfr_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_mark_ram (
      .clock (clock), .we (mark_we), .addr (mark_addr), .wdata (mark_wd), .rdata (mark_rd)
   );

   lfr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_prev_ram (
      .clock (clock), .we (prev_we), .addr (prev_addr), .wdata (prev_wd), .rdata (prev_rd)
   );

   lfr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_next_ram (
      .clock (clock), .we (next_we), .addr (next_addr), .wdata (next_wd), .rdata (next_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= lfr_pkg::LIMIT_RESET;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      frame_ff     <= frame_in;
      res_ok_ff    <= res_ok_in;
      res_vf_ff    <= res_vf_in;
      res_drop_ff  <= res_drop_in;
      out_ok_ff    <= out_ok_in;
      out_vf_ff    <= out_vf_in;
      out_drop_ff  <= out_drop_in;
      out_count_ff <= out_count_in;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      limit_in     = csr_valid ? csr_list_limit : limit_ff;
      clr_in       = ctrl.clear_en ? clr_ff + 1'b1 : clr_ff;
      res_ok_in    = res_ok_ff;
      res_vf_in    = res_vf_ff;
      res_drop_in  = res_drop_ff;

      mark_we   = 1'b0;
      mark_addr = x_idx;
      mark_wd   = 1'b0;
      prev_we   = 1'b0;
      prev_addr = x_idx;
      prev_wd   = tail_ff;
      next_we   = 1'b0;
      next_addr = x_idx;
      next_wd   = x_idx;

      if (ctrl.clear_en) begin
         mark_we   = 1'b1;
         mark_addr = clr_ff;
      end

      // issue reads straight from the request word; victim and unpin need next of head
      if (ctrl.capture) begin
         cmd_in    = lfr_pkg::cmd_type'(req_cmd);
         frame_in  = req_frame;
         mark_addr = FW'(req_frame);
         prev_addr = FW'(req_frame);
         next_addr = (lfr_pkg::cmd_type'(req_cmd) == lfr_pkg::CMD_PIN) ?
                     FW'(req_frame) : head_ff;
      end

      if (ctrl.exec_en) begin
         res_ok_in   = 1'b0;
         res_vf_in   = '0;
         res_drop_in = 1'b0;
         case (cmd_ff)
            lfr_pkg::CMD_VICTIM: begin
               if (count_ff != '0) begin
                  mark_we   = 1'b1;
                  mark_addr = head_ff;
                  head_in   = next_rd;
                  count_in  = count_ff - 1'b1;
                  res_ok_in = 1'b1;
                  res_vf_in = lfr_pkg::FRAME_W'(head_ff);
               end
            end
            lfr_pkg::CMD_PIN: begin
               if (frame_ok && mark_rd) begin
                  mark_we   = 1'b1;
                  mark_addr = x_idx;
                  count_in  = count_ff - 1'b1;
                  if (x_idx == head_ff) begin
                     head_in = next_rd;
                  end else begin
                     next_we   = 1'b1;
                     next_addr = prev_rd;
                     next_wd   = next_rd;
                  end
                  if (x_idx == tail_ff) begin
                     tail_in = prev_rd;
                  end else begin
                     prev_we   = 1'b1;
                     prev_addr = next_rd;
                     prev_wd   = prev_rd;
                  end
               end
            end
            lfr_pkg::CMD_UNPIN: begin
               if (frame_ok && !mark_rd && drop_need) begin
                  mark_we     = 1'b1;
                  mark_addr   = head_ff;
                  head_in     = next_rd;
                  count_in    = count_ff - 1'b1;
                  res_drop_in = 1'b1;
               end
            end
            default: begin
               res_ok_in = 1'b0;
            end
         endcase
      end

      if (ctrl.append_en) begin
         mark_we   = 1'b1;
         mark_addr = x_idx;
         mark_wd   = 1'b1;
         tail_in   = x_idx;
         count_in  = count_ff + 1'b1;
         if (count_ff == '0) begin
            head_in = x_idx;
         end else begin
            next_we   = 1'b1;
            next_addr = tail_ff;
            next_wd   = x_idx;
            prev_we   = 1'b1;
            prev_addr = x_idx;
            prev_wd   = tail_ff;
         end
      end
   end

   // output word register; a finished word waits here for rsp_ready
   always_comb begin
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_vf_in    = out_vf_ff;
      out_drop_in  = out_drop_ff;
      out_count_in = out_count_ff;
      if (ctrl.load_out) begin
         out_valid_in = 1'b1;
         out_ok_in    = res_ok_ff;
         out_vf_in    = res_vf_ff;
         out_drop_in  = res_drop_ff;
         out_count_in = count_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_ok           = out_ok_ff;
   assign rsp_victim_frame = out_vf_ff;
   assign rsp_dropped      = out_drop_ff;
   assign rsp_count        = out_count_ff;

endmodule

@@ hdl/lru_frame_replacer_core.sv @@
// A word accepted on req_ch issues a registered read of the link memories, then an update
// step and, for an unpin that appends, an append step, before it enters the output register.
// Each link memory has a single port; no new word is taken until the last has been loaded
// into the output register; a finished word may wait there for rsp_ch.ready.
// Reset (synchronous): list empties, list_limit = 64; the membership memory is then cleared
// entry by entry with req_ch.ready low. csr_ch is always ready.
module lru_frame_replacer_core #(
   parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lfr_req_if.sink   req_ch,
   lfr_rsp_if.source rsp_ch,
   lfr_csr_if.sink   csr_ch
);

   lfr_pkg::ctrl_cmd_type  ctrl;
   lfr_pkg::dp_status_type status;

   assign csr_ch.ready = 1'b1;

   lfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   lfr_dp #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_cmd          (req_ch.cmd),
      .req_frame        (req_ch.frame),
      .csr_valid        (csr_ch.valid),
      .csr_list_limit   (csr_ch.list_limit),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ok           (rsp_ch.ok),
      .rsp_victim_frame (rsp_ch.victim_frame),
      .rsp_dropped      (rsp_ch.dropped),
      .rsp_count        (rsp_ch.count)
   );

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> ctrl.exec_en)
      else $error("accepted word not executed next cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> 32'(rsp_ch.count) <= 32'(NUM_FRAMES))
      else $error("count above frame total");

   a_ok_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ok |-> !rsp_ch.dropped)
      else $error("victim word flags a drop");

   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.dropped |-> rsp_ch.count != '0)
      else $error("drop without append");

endmodule
